// ----- rtl/bhtdr_pkg.sv -----
// Package with sizes, command codes and the entry record of the position table.
package bhtdr_pkg;
   localparam int BUCKET_COUNT = 1024;
   localparam int WAYS = 4;
   localparam int BUCKET_BITS = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_BITS = $clog2(WAYS + 1);
   localparam int KEY_BITS = 64;
   localparam int SCORE_BITS = 10;

   localparam logic [1:0] CMD_PROBE = 2'd0;
   localparam logic [1:0] CMD_SET_MOVE = 2'd1;
   localparam logic [1:0] CMD_SET_BOUND = 2'd2;
   localparam logic [1:0] BOUND_EXACT = 2'd1;

   typedef struct packed {
      logic [7:0] move_ply;
      logic [15:0] move;
      logic [7:0] eval_ply;
      logic [1:0] bound;
      logic signed [15:0] eval;
   } entry_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      entry_type entry;
   } way_type;

   function automatic logic [SCORE_BITS-1:0] entry_score(input entry_type e);
      return {1'b0, e.eval_ply, 1'b0} + {2'b00, e.move_ply};
   endfunction
endpackage

// ----- rtl/bhtdr_bucket_ram.sv -----
// Bucket memory: all ways of one bucket in one row, plus the fill count row.
module bhtdr_bucket_ram (
   input  logic clock,
   input  logic rd_en,
   input  logic [bhtdr_pkg::BUCKET_BITS-1:0] rd_addr,
   output bhtdr_pkg::way_type [bhtdr_pkg::WAYS-1:0] rd_ways,
   output logic [bhtdr_pkg::FILL_BITS-1:0] rd_fill,
   input  logic wr_en,
   input  logic [bhtdr_pkg::BUCKET_BITS-1:0] wr_addr,
   input  logic [bhtdr_pkg::WAY_BITS-1:0] wr_way,
   input  bhtdr_pkg::way_type wr_data,
   input  logic [bhtdr_pkg::FILL_BITS-1:0] wr_fill,
   input  logic clr_en,
   input  logic [bhtdr_pkg::BUCKET_BITS-1:0] clr_addr
);
   import bhtdr_pkg::*;

   way_type [WAYS-1:0] mem_ways [BUCKET_COUNT];
   logic [FILL_BITS-1:0] mem_fill [BUCKET_COUNT];

   // One row holds a whole bucket; a write updates a single way of the row.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ways[wr_addr][wr_way] <= wr_data;
      end
      if (rd_en) begin
         rd_ways <= mem_ways[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_en) begin
         mem_fill[clr_addr] <= '0;
      end else if (wr_en) begin
         mem_fill[wr_addr] <= wr_fill;
      end
      if (rd_en) begin
         rd_fill <= mem_fill[rd_addr];
      end
   end
endmodule

// ----- rtl/bhtdr_update.sv -----
// Combinational hit search, update decision and victim selection for one bucket.
module bhtdr_update (
   input  bhtdr_pkg::way_type [bhtdr_pkg::WAYS-1:0] ways,
   input  logic [bhtdr_pkg::FILL_BITS-1:0] fill,
   input  logic [1:0] cmd,
   input  logic [bhtdr_pkg::KEY_BITS-1:0] key,
   input  logic [15:0] move_code,
   input  logic signed [15:0] score_value,
   input  logic [7:0] search_depth,
   input  logic [1:0] bound_kind,
   output logic found,
   output logic do_write,
   output logic [bhtdr_pkg::WAY_BITS-1:0] way_sel,
   output logic [bhtdr_pkg::FILL_BITS-1:0] fill_next,
   output bhtdr_pkg::entry_type new_entry,
   output bhtdr_pkg::entry_type out_entry
);
   import bhtdr_pkg::*;

   logic [WAY_BITS-1:0] hit_way, victim;
   logic [SCORE_BITS-1:0] vscore;
   entry_type cur;
   logic want;

   always_comb begin
      found = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && (FILL_BITS'(w) < fill) && ways[w].key == key) begin
            found = 1'b1;
            hit_way = WAY_BITS'(w);
         end
      end
      cur = found ? ways[hit_way].entry : '0;

      new_entry = cur;
      want = 1'b0;
      case (cmd)
         CMD_SET_MOVE: begin
            want = !(found && cur.move_ply > search_depth);
            new_entry.move = move_code;
            new_entry.move_ply = search_depth;
         end
         CMD_SET_BOUND: begin
            want = !(found && (cur.eval_ply > search_depth ||
               (cur.eval_ply == search_depth && cur.bound == BOUND_EXACT &&
                bound_kind != BOUND_EXACT)));
            new_entry.eval = score_value;
            new_entry.bound = bound_kind;
            new_entry.eval_ply = search_depth;
         end
         default: want = 1'b0;
      endcase

      // The first way with the strictly lowest score becomes the victim.
      victim = '0;
      vscore = entry_score(ways[0].entry);
      for (int w = 1; w < WAYS; w++) begin
         if (entry_score(ways[w].entry) < vscore) begin
            victim = WAY_BITS'(w);
            vscore = entry_score(ways[w].entry);
         end
      end

      fill_next = fill;
      do_write = 1'b0;
      way_sel = hit_way;
      if (want) begin
         if (found) begin
            do_write = 1'b1;
         end else if (fill < FILL_BITS'(WAYS)) begin
            do_write = 1'b1;
            way_sel = WAY_BITS'(fill);
            fill_next = fill + 1'b1;
         end else begin
            way_sel = victim;
            do_write = !(entry_score(new_entry) < vscore);
         end
      end

      if (do_write) begin
         out_entry = new_entry;
      end else begin
         out_entry = cur;
      end
   end
endmodule

// ----- rtl/bucketed_hash_table_depth_replace_top.sv -----
// Top level of the set-associative position table with depth-preferred replacement.
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_cmd .. req_bound_kind
//  rsp     | out       | rsp_valid, rsp_stall, rsp_found .. rsp_entry_move_depth
// An item is accepted at one edge, which also reads its bucket. In ST_WORK the
// bucket is compared; the edge that leaves ST_WORK, with the result register
// free or being taken, writes back and loads that register. Only back in ST_IDLE
// can a new item be accepted, so bucket read-modify-writes never overlap.
// After reset a clearing pass zeroes the fill count of every bucket, with
// req_stall high. A stalled result holds, and the write-back of the next
// item waits until the result register is free or being taken.
module bucketed_hash_table_depth_replace_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_cmd,
   input  logic [63:0] req_key,
   input  logic [15:0] req_move_code,
   input  logic signed [15:0] req_score_value,
   input  logic [7:0] req_search_depth,
   input  logic [1:0] req_bound_kind,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_found,
   output logic rsp_written,
   output logic signed [15:0] rsp_entry_eval,
   output logic [1:0] rsp_entry_bound,
   output logic [7:0] rsp_entry_eval_depth,
   output logic [15:0] rsp_entry_move,
   output logic [7:0] rsp_entry_move_depth
);
   import bhtdr_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_WORK = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [BUCKET_BITS:0] clr_ff, clr_in;
   logic [1:0] cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [15:0] move_ff;
   logic signed [15:0] score_ff;
   logic [7:0] depth_ff;
   logic [1:0] bound_ff;
   logic rsp_valid_ff;
   logic found_ff, written_ff;
   entry_type entry_ff;

   way_type [WAYS-1:0] rd_ways;
   way_type wr_way_data;
   logic [FILL_BITS-1:0] rd_fill, fill_next;
   logic found, do_write;
   logic [WAY_BITS-1:0] way_sel;
   entry_type new_entry, out_entry;
   logic accept, out_free;
   logic [BUCKET_BITS-1:0] req_bucket, cur_bucket;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign req_bucket = BUCKET_BITS'(req_key % BUCKET_COUNT);
   assign cur_bucket = BUCKET_BITS'(key_ff % BUCKET_COUNT);
   assign wr_way_data.key = key_ff;
   assign wr_way_data.entry = new_entry;

   bhtdr_bucket_ram u_ram (
      .clock(clock),
      .rd_en(accept), .rd_addr(req_bucket),
      .rd_ways(rd_ways), .rd_fill(rd_fill),
      .wr_en(state_ff == ST_WORK && out_free && do_write),
      .wr_addr(cur_bucket), .wr_way(way_sel),
      .wr_data(wr_way_data), .wr_fill(fill_next),
      .clr_en(state_ff == ST_CLEAR), .clr_addr(clr_ff[BUCKET_BITS-1:0])
   );

   bhtdr_update u_upd (
      .ways(rd_ways), .fill(rd_fill), .cmd(cmd_ff), .key(key_ff),
      .move_code(move_ff), .score_value(score_ff), .search_depth(depth_ff),
      .bound_kind(bound_ff), .found(found), .do_write(do_write),
      .way_sel(way_sel), .fill_next(fill_next), .new_entry(new_entry),
      .out_entry(out_entry)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (BUCKET_BITS+1)'(BUCKET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: if (accept) state_in = ST_WORK;
         ST_WORK: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (state_ff == ST_WORK && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         move_ff <= req_move_code;
         score_ff <= req_score_value;
         depth_ff <= req_search_depth;
         bound_ff <= req_bound_kind;
      end
      if (state_ff == ST_WORK && out_free) begin
         found_ff <= found;
         written_ff <= do_write;
         entry_ff <= out_entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_written = written_ff;
   assign rsp_entry_eval = entry_ff.eval;
   assign rsp_entry_bound = entry_ff.bound;
   assign rsp_entry_eval_depth = entry_ff.eval_ply;
   assign rsp_entry_move = entry_ff.move;
   assign rsp_entry_move_depth = entry_ff.move_ply;
endmodule

// ----- test/bucketed_hash_table_depth_replace_top_test.sv -----
// Testbench for the set-associative position table with depth-preferred replacement.
`timescale 1ns / 100ps

module bucketed_hash_table_depth_replace_top_test;
   import bhtdr_pkg::*;

   typedef struct {
      logic [1:0] cmd;
      logic [63:0] key;
      logic [15:0] move_code;
      logic signed [15:0] score_value;
      logic [7:0] search_depth;
      logic [1:0] bound_kind;
   } probe_item_type;

   typedef struct {
      logic found;
      logic written;
      logic signed [15:0] eval;
      logic [1:0] bound;
      logic [7:0] eval_ply;
      logic [15:0] move;
      logic [7:0] move_ply;
   } table_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [63:0] req_key = '0;
   logic [15:0] req_move_code = '0;
   logic signed [15:0] req_score_value = '0;
   logic [7:0] req_search_depth = '0;
   logic [1:0] req_bound_kind = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic rsp_written;
   logic signed [15:0] rsp_entry_eval;
   logic [1:0] rsp_entry_bound;
   logic [7:0] rsp_entry_eval_depth;
   logic [15:0] rsp_entry_move;
   logic [7:0] rsp_entry_move_depth;

   probe_item_type pending_items[$];
   table_answer_type expected_answers[$];
   int error_count = 0;
   int answer_count = 0;
   int written_count = 0;

   // Shadow copy of the table.
   logic [63:0] shadow_keys[BUCKET_COUNT*WAYS];
   entry_type shadow_entries[BUCKET_COUNT*WAYS];
   int shadow_fill[BUCKET_COUNT];

   // A small pool of keys crowded into a few buckets drives hits and evictions.
   logic [63:0] key_pool[32];

   bucketed_hash_table_depth_replace_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int lookup_way(int bucket, logic [63:0] key);
      for (int w = 0; w < shadow_fill[bucket]; w++)
         if (shadow_keys[bucket*WAYS+w] == key) return w;
      return -1;
   endfunction

   function automatic int score_of(entry_type e);
      return 2 * int'(e.eval_ply) + int'(e.move_ply);
   endfunction

   function automatic logic store_entry(int bucket, logic [63:0] key, entry_type e);
      int base;
      int hit;
      int victim;
      base = bucket * WAYS;
      victim = 0;
      hit = lookup_way(bucket, key);
      if (hit >= 0) begin
         shadow_entries[base+hit] = e;
         return 1'b1;
      end
      if (shadow_fill[bucket] < WAYS) begin
         shadow_keys[base+shadow_fill[bucket]] = key;
         shadow_entries[base+shadow_fill[bucket]] = e;
         shadow_fill[bucket]++;
         return 1'b1;
      end
      for (int w = 1; w < WAYS; w++)
         if (score_of(shadow_entries[base+w]) < score_of(shadow_entries[base+victim]))
            victim = w;
      if (score_of(e) < score_of(shadow_entries[base+victim])) return 1'b0;
      shadow_keys[base+victim] = key;
      shadow_entries[base+victim] = e;
      return 1'b1;
   endfunction

   function automatic table_answer_type apply_table_item(probe_item_type it);
      table_answer_type a;
      entry_type cur;
      int bucket;
      int hit;
      logic refuse;
      bucket = int'(it.key % BUCKET_COUNT);
      hit = lookup_way(bucket, it.key);
      a.found = hit >= 0;
      a.written = 1'b0;
      cur = '0;
      if (a.found) cur = shadow_entries[bucket*WAYS+hit];
      if (it.cmd == CMD_SET_MOVE) begin
         if (!(a.found && cur.move_ply > it.search_depth)) begin
            cur.move = it.move_code;
            cur.move_ply = it.search_depth;
            a.written = store_entry(bucket, it.key, cur);
         end
      end else if (it.cmd == CMD_SET_BOUND) begin
         refuse = a.found && (cur.eval_ply > it.search_depth ||
            (cur.eval_ply == it.search_depth && cur.bound == BOUND_EXACT &&
             it.bound_kind != BOUND_EXACT));
         if (!refuse) begin
            cur.eval = it.score_value;
            cur.bound = it.bound_kind;
            cur.eval_ply = it.search_depth;
            a.written = store_entry(bucket, it.key, cur);
         end
      end
      hit = lookup_way(bucket, it.key);
      cur = '0;
      if (hit >= 0) cur = shadow_entries[bucket*WAYS+hit];
      a.eval = cur.eval;
      a.bound = cur.bound;
      a.eval_ply = cur.eval_ply;
      a.move = cur.move;
      a.move_ply = cur.move_ply;
      return a;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(99) < 40) return 0;
      if ($urandom_range(99) < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 4);
   endfunction

   task automatic add_item(logic [1:0] cmd, logic [63:0] key, logic [15:0] mv,
                           logic [15:0] ev, logic [7:0] depth, logic [1:0] bk);
      probe_item_type it;
      it.cmd = cmd;
      it.key = key;
      it.move_code = mv;
      it.score_value = ev;
      it.search_depth = depth;
      it.bound_kind = bk;
      pending_items.insert(pending_items.size(), it);
   endtask

   initial begin
      logic [63:0] k;
      for (int i = 0; i < BUCKET_COUNT; i++) shadow_fill[i] = 0;
      for (int i = 0; i < 32; i++)
         key_pool[i] = {$urandom, $urandom} & ~64'h3FF | 64'(i % 3);
      // Directed part: extremes, every command, equal-depth bound, refused
      // replacement, unused command, rewrite with equal contents.
      k = 64'hFFFF_FFFF_FFFF_FC05;
      add_item(CMD_PROBE, k, 16'h0, 16'h0, 8'h0, 2'd0);
      add_item(CMD_SET_MOVE, k, 16'hFFFF, 16'h0, 8'd10, 2'd0);
      add_item(CMD_SET_MOVE, k, 16'hFFFF, 16'h0, 8'd10, 2'd0);
      add_item(CMD_SET_MOVE, k, 16'h1234, 16'h0, 8'd9, 2'd0);
      add_item(CMD_SET_BOUND, k, 16'h0, 16'sh7FFF, 8'd20, BOUND_EXACT);
      add_item(CMD_SET_BOUND, k, 16'h0, 16'sh8000, 8'd20, 2'd2);
      add_item(CMD_SET_BOUND, k, 16'h0, 16'sh8000, 8'd20, 2'd3);
      add_item(CMD_SET_BOUND, k, 16'h0, 16'sh8000, 8'd21, 2'd3);
      add_item(CMD_SET_BOUND, k, 16'h0, 16'h0, 8'd255, 2'd0);
      add_item(2'd3, k, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3);
      add_item(CMD_SET_MOVE, 64'h0, 16'h0, 16'h0, 8'd0, 2'd0);
      for (int i = 1; i <= 4; i++)
         add_item(CMD_SET_MOVE, 64'(i) << 10 | 64'd7, 16'(i), 16'h0, 8'd50, 2'd0);
      add_item(CMD_SET_MOVE, 64'd5 << 10 | 64'd7, 16'h5, 16'h0, 8'd10, 2'd0);
      add_item(CMD_SET_BOUND, 64'd6 << 10 | 64'd7, 16'h0, 16'h55, 8'd255, 2'd2);
      add_item(CMD_PROBE, 64'd1 << 10 | 64'd7, 16'h0, 16'h0, 8'd0, 2'd0);
      add_item(CMD_SET_MOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hAAAA, 16'h0, 8'hFF, 2'd0);
      for (int n = 0; n < 1900; n++) begin
         if ($urandom_range(99) < 80) k = key_pool[$urandom_range(31)];
         else k = {$urandom, $urandom};
         add_item(2'($urandom_range(99) < 5 ? 3 : $urandom_range(2)), k,
                  16'($urandom), 16'($urandom),
                  8'($urandom_range(99) < 70 ? $urandom_range(40) : $urandom_range(255)),
                  2'($urandom));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_answers.insert(expected_answers.size(),
               apply_table_item('{req_cmd, req_key, req_move_code,
                  req_score_value, req_search_depth, req_bound_kind}));
            req_gap = gap_length();
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0 || pending_items.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_valid <= 1'b0;
            end else begin
               probe_item_type it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_cmd <= it.cmd;
               req_key <= it.key;
               req_move_code <= it.move_code;
               req_score_value <= it.score_value;
               req_search_depth <= it.search_depth;
               req_bound_kind <= it.bound_kind;
            end
         end
      end
   end

   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            table_answer_type e;
            answer_count++;
            if (expected_answers.size() == 0) begin
               $error("result with no item outstanding");
               error_count++;
            end else begin
               e = expected_answers.pop_front();
               written_count += e.written;
               if (rsp_found !== e.found) begin
                  $error("found: expected %0d, got %0d", e.found, rsp_found);
                  error_count++;
               end
               if (rsp_written !== e.written) begin
                  $error("written: expected %0d, got %0d", e.written, rsp_written);
                  error_count++;
               end
               if (rsp_entry_eval !== e.eval) begin
                  $error("entry_eval: expected %0d, got %0d", e.eval, rsp_entry_eval);
                  error_count++;
               end
               if (rsp_entry_bound !== e.bound) begin
                  $error("entry_bound: expected %0d, got %0d", e.bound, rsp_entry_bound);
                  error_count++;
               end
               if (rsp_entry_eval_depth !== e.eval_ply) begin
                  $error("entry_eval_depth: expected %0d, got %0d", e.eval_ply,
                         rsp_entry_eval_depth);
                  error_count++;
               end
               if (rsp_entry_move !== e.move) begin
                  $error("entry_move: expected %0d, got %0d", e.move, rsp_entry_move);
                  error_count++;
               end
               if (rsp_entry_move_depth !== e.move_ply) begin
                  $error("entry_move_depth: expected %0d, got %0d", e.move_ply,
                         rsp_entry_move_depth);
                  error_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < 30) begin
            rsp_gap = gap_length();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      wait (!reset);
      @(posedge clock);
      wait (pending_items.size() == 0 && !req_valid && expected_answers.size() == 0);
      repeat (20) @(posedge clock);
      $display("Ran %0d table items through probe, move and bound updates; %0d wrote a way.",
               answer_count, written_count);
      if (error_count == 0 && expected_answers.size() == 0)
         $display("bucketed_hash_table_depth_replace_top verification clean");
      else
         $display("bucketed_hash_table_depth_replace_top verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("bucketed_hash_table_depth_replace_top verification failed");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/bhtdr_pkg.sv
rtl/bhtdr_bucket_ram.sv
rtl/bhtdr_update.sv
rtl/bucketed_hash_table_depth_replace_top.sv
test/bucketed_hash_table_depth_replace_top_test.sv
